// ===== rtl/srbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbc_pkg
// Shared types and constants of the strand read bin counter: item structs,
// flag bits, register indexes and the divider request/response bundles.
// ----------------------------------------------------------------------------
package srbc_pkg;

	// default number of bins per strand store
	localparam int BIN_COUNT_DEF = 1024;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAPQ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IVL_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IVL_END   = 2'd3;

	// register reset values
	localparam logic [7:0]  MIN_MAPQ_RST = 8'd1;
	localparam logic [23:0] SEG_SIZE_RST = 24'd5000;

	// SAM flag bits
	localparam logic [15:0] FLAG_UNMAPPED      = 16'h0004;
	localparam logic [15:0] FLAG_REVERSE       = 16'h0010;
	localparam logic [15:0] FLAG_FIRST         = 16'h0040;
	localparam logic [15:0] FLAG_SECONDARY     = 16'h0100;
	localparam logic [15:0] FLAG_QCFAIL        = 16'h0200;
	localparam logic [15:0] FLAG_DUPLICATE     = 16'h0400;
	localparam logic [15:0] FLAG_SUPPLEMENTARY = 16'h0800;
	localparam logic [15:0] FLAG_DROP_MASK     = FLAG_UNMAPPED | FLAG_SECONDARY |
		FLAG_QCFAIL | FLAG_DUPLICATE | FLAG_SUPPLEMENTARY;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// divider step counts
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_BIN   = 6'd32;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RATIO = 6'd17;

	// input item
	typedef struct packed {
		logic               kind;
		logic [15:0]        read_flags;
		logic [7:0]         map_quality;
		logic signed [31:0] ref_id;
		logic [30:0]        read_start;
		logic [19:0]        half_length;
		logic [9:0]         report_bin;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [9:0]  bin_number;
		logic [30:0] region_first;
		logic [30:0] region_last;
		logic [31:0] watson_total;
		logic [31:0] crick_total;
		logic [32:0] support;
		logic [16:0] watson_ratio;
	} out_item_t;

	// divider request: remainder preload, bits shifted in MSB first, divisor
	typedef struct packed {
		logic                 go;
		logic [32:0]          rem_init;
		logic [31:0]          num;
		logic [32:0]          den;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/strand_read_bin_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strand_read_bin_counter
// Filters aligned-read items, bins them by midpoint and counts them per strand;
// report items read out and clear one bin with region bounds and watson ratio.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  input    | start, busy           | item   (in_item_t)
//  result   | result_valid (strobe) | result (out_item_t)
//  config   | cfg_we                | cfg_index, cfg_data
//
// A counted read holds busy through the midpoint and divider-start states, the
// 32 steps of the shared divider for the bin index plus its done cycle, then the
// write-back. A report item holds busy through store read, clear, region
// arithmetic next to the 17 divider steps for the ratio, and the done cycle.
// A dropped read ends after the divider-start state (after the divider when its
// bin is past the store), a report without support after the clear; the result
// strobe comes as busy drops. After reset the store is cleared one entry a cycle
// with busy high. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module strand_read_bin_counter import srbc_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  result_valid,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam logic [31:0]   BIN_LIMIT = 32'(BIN_COUNT);
	localparam logic [BW-1:0] BIN_LAST  = BW'(BIN_COUNT - 1);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_CNT_MID,
		S_CNT_GO,
		S_CNT_DIV,
		S_CNT_WR,
		S_RPT_RD,
		S_RPT_CHK,
		S_RPT_ADD,
		S_RPT_NXT,
		S_RPT_DIV
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0]  min_mapq_q;
	logic [23:0] seg_q;
	logic [30:0] ivl_start_q;
	logic [30:0] ivl_end_q;

	// control
	logic [BW-1:0] clr_q;
	logic          result_valid_q;
	out_item_t     result_q;

	// datapath
	in_item_t      item_q;
	logic [31:0]   mid_q;
	logic [BW-1:0] addr_q;
	logic [31:0]   w_q;
	logic [31:0]   c_q;
	logic [32:0]   sup_q;
	logic [33:0]   prod_q;
	logic [34:0]   first_q;
	logic [35:0]   next_q;

	logic [23:0]   seg_eff;
	logic          filt_ok;
	logic          in_range;
	logic [31:0]   mid_off;
	logic [31:0]   rb_ext;
	logic          rb_ok;
	logic          quot_ok;
	logic          is_crick;
	logic [31:0]   rd_w;
	logic [31:0]   rd_c;
	logic [32:0]   rd_sup;
	logic [31:0]   w_bump;
	logic [31:0]   c_bump;

	logic          ram_we;
	logic [BW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [BW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// bin store: watson in the upper half, crick in the lower
	srbc_ram #(
		.WIDTH(64),
		.DEPTH(BIN_COUNT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	srbc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// filters and bin checks
	assign seg_eff  = (seg_q == '0) ? 24'd1 : seg_q;
	assign filt_ok  = ((item_q.read_flags & FLAG_DROP_MASK) == '0) &&
		(item_q.map_quality >= min_mapq_q) && !item_q.ref_id[31];
	assign in_range = (mid_q >= {1'b0, ivl_start_q}) && (mid_q < {1'b0, ivl_end_q});
	assign mid_off  = mid_q - {1'b0, ivl_start_q};
	assign rb_ext   = {22'b0, item_q.report_bin};
	assign rb_ok    = rb_ext < BIN_LIMIT;
	assign quot_ok  = div_rsp.quot < BIN_LIMIT;

	// strand choice and saturating bump
	assign is_crick = ((item_q.read_flags & FLAG_FIRST) != '0) ==
		((item_q.read_flags & FLAG_REVERSE) != '0);
	assign rd_w     = ram_rdata[63:32];
	assign rd_c     = ram_rdata[31:0];
	assign rd_sup   = {1'b0, rd_w} + {1'b0, rd_c};
	assign w_bump   = (!is_crick && rd_w != COUNT_MAX) ? rd_w + 32'd1 : rd_w;
	assign c_bump   = (is_crick && rd_c != COUNT_MAX) ? rd_c + 32'd1 : rd_c;

	// store and divider control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		div_req   = '0;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_CNT_GO: begin
				div_req.go    = filt_ok && in_range;
				div_req.num   = mid_off;
				div_req.den   = {9'b0, seg_eff};
				div_req.steps = DIV_STEPS_BIN;
			end
			S_CNT_DIV: begin
				ram_raddr = div_rsp.quot[BW-1:0];
			end
			S_CNT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {w_bump, c_bump};
			end
			S_RPT_RD: begin
				ram_raddr = rb_ext[BW-1:0];
			end
			S_RPT_CHK: begin
				ram_we = 1'b1;
			end
			S_RPT_ADD: begin
				// w <= support, so the quotient fits 17 bits after preloading w >> 1
				div_req.go       = 1'b1;
				div_req.rem_init = {2'b0, w_q[31:1]};
				div_req.num      = {w_q[0], 31'b0};
				div_req.den      = sup_q;
				div_req.steps    = DIV_STEPS_RATIO;
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mapq_q  <= MIN_MAPQ_RST;
			seg_q       <= SEG_SIZE_RST;
			ivl_start_q <= '0;
			ivl_end_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_MAPQ:  min_mapq_q  <= cfg_data[7:0];
				CFG_SEG_SIZE:  seg_q       <= cfg_data[23:0];
				CFG_IVL_START: ivl_start_q <= cfg_data;
				CFG_IVL_END:   ivl_end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= item.kind ? S_RPT_RD : S_CNT_MID;
					end
				end
				S_CNT_MID: begin
					state_q <= S_CNT_GO;
				end
				S_CNT_GO: begin
					state_q <= (filt_ok && in_range) ? S_CNT_DIV : S_IDLE;
				end
				S_CNT_DIV: begin
					if (div_rsp.done) begin
						state_q <= quot_ok ? S_CNT_WR : S_IDLE;
					end
				end
				S_CNT_WR: begin
					state_q <= S_IDLE;
				end
				S_RPT_RD: begin
					state_q <= rb_ok ? S_RPT_CHK : S_IDLE;
				end
				S_RPT_CHK: begin
					state_q <= (rd_sup == '0) ? S_IDLE : S_RPT_ADD;
				end
				S_RPT_ADD: begin
					state_q <= S_RPT_NXT;
				end
				S_RPT_NXT: begin
					state_q <= S_RPT_DIV;
				end
				S_RPT_DIV: begin
					if (div_rsp.done) begin
						state_q                <= S_IDLE;
						result_valid_q         <= 1'b1;
						result_q.bin_number    <= item_q.report_bin;
						result_q.region_first  <= first_q[30:0];
						result_q.region_last   <= (next_q > {5'b0, ivl_end_q}) ?
							ivl_end_q : next_q[30:0];
						result_q.watson_total  <= w_q;
						result_q.crick_total   <= c_q;
						result_q.support       <= sup_q;
						result_q.watson_ratio  <= div_rsp.quot[16:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == S_CNT_MID) begin
			mid_q <= {1'b0, item_q.read_start} + {12'b0, item_q.half_length};
		end
		if (state_q == S_CNT_DIV && div_rsp.done) begin
			addr_q <= div_rsp.quot[BW-1:0];
		end
		if (state_q == S_RPT_RD) begin
			addr_q <= rb_ext[BW-1:0];
		end
		if (state_q == S_RPT_CHK) begin
			w_q    <= rd_w;
			c_q    <= rd_c;
			sup_q  <= rd_sup;
			prod_q <= 34'(item_q.report_bin) * 34'(seg_eff);
		end
		if (state_q == S_RPT_ADD) begin
			first_q <= {1'b0, prod_q} + {4'b0, ivl_start_q};
		end
		if (state_q == S_RPT_NXT) begin
			next_q <= {1'b0, first_q} + {12'b0, seg_eff};
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/srbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/srbc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbc_div
// Shared restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so that short quotients need only as many steps as they have bits.
// ----------------------------------------------------------------------------
module srbc_div import srbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          rem_q;
	logic [31:0]          num_q;
	logic [32:0]          den_q;
	logic [31:0]          quo_q;

	logic [33:0] trial;
	logic [33:0] trial_sub;
	logic        ge;

	// one compare-subtract step
	assign trial     = {rem_q, num_q[31]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.rem_init;
			num_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? trial_sub[32:0] : trial[32:0];
			num_q <= {num_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule
